@@ rtl/core/ntt_tfg_pkg.sv @@
// Shared constants, types and modular arithmetic helpers for the twiddle generator.
package ntt_tfg_pkg;

    // Table position width and field widths
    localparam int INDEX_BITS   = 7;
    localparam int W_CMD        = 2;
    localparam int W_COEF       = 12;
    localparam int W_PROD       = 2 * W_COEF;

    // Modulus and derived constants
    localparam int Q            = 3329;
    localparam int HALF_Q       = 1664;
    localparam int RESET_ROOT   = 17;
    localparam int MONT_SHIFT   = 16;
    localparam int MONT_R       = (1 << MONT_SHIFT) % Q;

    // Barrett reduction of a product below 2^W_PROD
    localparam int BARRETT_SHIFT = W_PROD;
    localparam int BARRETT_M     = (1 << BARRETT_SHIFT) / Q;
    localparam int W_BM          = $clog2(BARRETT_M + 1);

    // One modular multiply unit per exponent bit, plus one for the Montgomery factor
    localparam int NUM_MM       = INDEX_BITS + 1;

    // Request queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int W_QPTR       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int W_QCNT       = $clog2(QUEUE_DEPTH + 1);

    // Squaring counter of the power table sequencer
    localparam int CNT_W        = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

    typedef enum logic [W_CMD-1:0] {
        CMD_FWD      = 2'd0,
        CMD_INV      = 2'd1,
        CMD_FWD_MONT = 2'd2,
        CMD_INV_MONT = 2'd3
    } t_cmd;

    // Classified request handed from front to back
    typedef struct packed {
        logic [INDEX_BITS-1:0] exp;
        logic                  inv;
        logic                  mont;
    } t_req;

    // root^(2^k) mod Q for k = 0 .. INDEX_BITS-1
    typedef logic [INDEX_BITS-1:0][W_COEF-1:0] t_pw_tab;

    typedef enum logic [2:0] {
        TBL_IDLE,
        TBL_LOAD,
        TBL_MUL,
        TBL_EST,
        TBL_FIX
    } t_tbl_state;

    // Mirror the bit order of a table position
    function automatic logic [INDEX_BITS-1:0] bit_rev(input logic [INDEX_BITS-1:0] v);
        logic [INDEX_BITS-1:0] r;
        for (int b = 0; b < INDEX_BITS; b++) begin
            r[INDEX_BITS-1-b] = v[b];
        end
        return r;
    endfunction

    // Quotient estimate: floor(x * M / 2^SHIFT), never more than one below x / Q
    function automatic logic [W_COEF-1:0] barrett_est(input logic [W_PROD-1:0] x);
        logic [W_PROD+W_BM-1:0] t;
        t = (W_PROD+W_BM)'(x) * (W_PROD+W_BM)'(BARRETT_M);
        return t[BARRETT_SHIFT +: W_COEF];
    endfunction

    // Remainder from the estimate, with one correcting subtract
    function automatic logic [W_COEF-1:0] barrett_fix(input logic [W_PROD-1:0] x,
                                                      input logic [W_COEF-1:0] qh);
        logic [W_PROD-1:0] qm;
        logic [W_PROD-1:0] r;
        qm = W_PROD'(qh) * W_PROD'(Q);
        r  = x - qm;
        if (r >= W_PROD'(Q)) begin
            r = r - W_PROD'(Q);
        end
        return r[W_COEF-1:0];
    endfunction

endpackage

@@ rtl/core/ntt_twiddle_factor_generator.sv @@
// Throughput: one request and one result per cycle, unless an untaken result stalls the
// pipeline; eight three-stage modular multipliers (seven exponent bits and the Montgomery
// factor) run as one stall-together pipeline.
// Reset: root returns to 17; full stays high while the table of root^(2^k) is rebuilt
// (load, then square, estimate and fix per further entry). Each root write starts the same rebuild.
module ntt_twiddle_factor_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ntt_tfg_pkg::W_CMD-1:0]     i_command,
    input  logic [ntt_tfg_pkg::INDEX_BITS-1:0] i_index,
    output logic                              empty,
    input  logic                              pop,
    output logic [ntt_tfg_pkg::W_COEF-1:0]    o_twiddle,
    input  logic                              i_cfg_we,
    input  logic [ntt_tfg_pkg::W_COEF-1:0]    i_cfg_data
);
    import ntt_tfg_pkg::*;

    logic    tbl_busy;
    t_pw_tab pw;
    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_req    req_in;
    t_req    req_out;

    // Root register and power table
    ntt_tfg_pow_table u_pow_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_busy     (tbl_busy),
        .o_pw       (pw)
    );

    // Request classification
    ntt_tfg_front u_front (
        .push       (push),
        .i_command  (i_command),
        .i_index    (i_index),
        .i_q_full   (q_full),
        .i_tbl_busy (tbl_busy),
        .full       (full),
        .o_q_push   (q_push),
        .o_req      (req_in)
    );

    // Front-to-back queue
    ntt_tfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (req_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (req_out)
    );

    // Exponentiation pipeline
    ntt_tfg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (~q_empty),
        .i_req     (req_out),
        .i_pw      (pw),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_twiddle (o_twiddle)
    );

`ifndef SYNTHESIS
    // A shown result is always centered
    a_tw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ($signed(o_twiddle) <= $signed(W_COEF'(HALF_Q)) &&
                    $signed(o_twiddle) >= -$signed(W_COEF'(HALF_Q))))
        else $error("twiddle outside centered range");

    // A root write always triggers a table rebuild
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> tbl_busy)
        else $error("root write did not start table rebuild");

    // First and last table entries stay reduced once built
    a_tbl_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tbl_busy |-> (pw[0] < W_COEF'(Q) && pw[INDEX_BITS-1] < W_COEF'(Q)))
        else $error("power table entry not reduced");
`endif

endmodule

@@ rtl/core/ntt_tfg_front.sv @@
// Front end: accepts requests and turns command and index into an exponent and flags.
module ntt_tfg_front (
    input  logic                                  push,
    input  logic [ntt_tfg_pkg::W_CMD-1:0]         i_command,
    input  logic [ntt_tfg_pkg::INDEX_BITS-1:0]    i_index,
    input  logic                                  i_q_full,
    input  logic                                  i_tbl_busy,
    output logic                                  full,
    output logic                                  o_q_push,
    output ntt_tfg_pkg::t_req                     o_req
);
    import ntt_tfg_pkg::*;

    logic                  inv;
    logic                  mont;
    logic [INDEX_BITS-1:0] pos;

    // Command decode
    always_comb begin
        case (t_cmd'(i_command))
            CMD_FWD:      begin inv = 1'b0; mont = 1'b0; end
            CMD_INV:      begin inv = 1'b1; mont = 1'b0; end
            CMD_FWD_MONT: begin inv = 1'b0; mont = 1'b1; end
            CMD_INV_MONT: begin inv = 1'b1; mont = 1'b1; end
            default:      begin inv = 1'b0; mont = 1'b0; end
        endcase
    end

    // Inverse tables read the mirrored position (all-ones minus index)
    assign pos = inv ? ~i_index : i_index;

    assign o_req.exp  = bit_rev(pos);
    assign o_req.inv  = inv;
    assign o_req.mont = mont;

    // No transfer while the power table is rebuilt or the queue is full
    assign full     = i_q_full | i_tbl_busy;
    assign o_q_push = push & ~full;

endmodule

@@ rtl/core/ntt_tfg_queue.sv @@
// Short request queue decoupling the front end from the arithmetic pipeline.
module ntt_tfg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ntt_tfg_pkg::t_req  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output ntt_tfg_pkg::t_req  o_data
);
    import ntt_tfg_pkg::*;

    t_req              r_mem [QUEUE_DEPTH];
    logic [W_QPTR-1:0] r_wr;
    logic [W_QPTR-1:0] r_rd;
    logic [W_QCNT-1:0] r_cnt;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_cnt == W_QCNT'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == W_QPTR'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == W_QPTR'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/core/ntt_tfg_pow_table.sv @@
// Root register and sequencer that builds root^(2^k) mod Q by repeated squaring.
module ntt_tfg_pow_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ntt_tfg_pkg::W_COEF-1:0]    i_cfg_data,
    output logic                              o_busy,
    output ntt_tfg_pkg::t_pw_tab              o_pw
);
    import ntt_tfg_pkg::*;

    t_tbl_state          r_state, n_state;
    logic [W_COEF-1:0]   r_root,  n_root;
    logic [W_COEF-1:0]   r_sq,    n_sq;
    logic [W_PROD-1:0]   r_x,     n_x;
    logic [W_COEF-1:0]   r_qh,    n_qh;
    t_pw_tab             r_pw,    n_pw;
    logic [CNT_W-1:0]    r_k,     n_k;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TBL_LOAD;
            r_root  <= W_COEF'(RESET_ROOT);
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_k     <= n_k;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
        r_x  <= n_x;
        r_qh <= n_qh;
        r_pw <= n_pw;
    end

    // Sequencer: load reduced root, then square/estimate/fix per further table entry
    always_comb begin
        logic [W_COEF-1:0] root_red;
        logic [W_COEF-1:0] val;
        t_pw_tab           shifted;

        root_red = (r_root >= W_COEF'(Q)) ? r_root - W_COEF'(Q) : r_root;
        val      = barrett_fix(r_x, r_qh);
        shifted  = r_pw >> W_COEF;

        n_state = r_state;
        n_root  = r_root;
        n_sq    = r_sq;
        n_x     = r_x;
        n_qh    = r_qh;
        n_pw    = r_pw;
        n_k     = r_k;

        case (r_state)
            TBL_IDLE: begin
                n_state = TBL_IDLE;
            end
            TBL_LOAD: begin
                n_sq                   = root_red;
                n_pw                   = shifted;
                n_pw[INDEX_BITS-1]     = root_red;
                n_k                    = '0;
                n_state                = (INDEX_BITS > 1) ? TBL_MUL : TBL_IDLE;
            end
            TBL_MUL: begin
                n_x     = W_PROD'(r_sq) * W_PROD'(r_sq);
                n_state = TBL_EST;
            end
            TBL_EST: begin
                n_qh    = barrett_est(r_x);
                n_state = TBL_FIX;
            end
            TBL_FIX: begin
                n_sq               = val;
                n_pw               = shifted;
                n_pw[INDEX_BITS-1] = val;
                if (r_k == CNT_W'(INDEX_BITS - 2)) begin
                    n_state = TBL_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = TBL_MUL;
                end
            end
            default: begin
                n_state = TBL_LOAD;
            end
        endcase

        // A new root restarts the build
        if (i_cfg_we) begin
            n_root  = i_cfg_data;
            n_state = TBL_LOAD;
        end
    end

    assign o_busy = (r_state != TBL_IDLE);
    assign o_pw   = r_pw;

endmodule

@@ rtl/core/ntt_tfg_back.sv @@
// Back end: chain of pipelined modular multipliers, centering and the result register.
module ntt_tfg_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  ntt_tfg_pkg::t_req                 i_req,
    input  ntt_tfg_pkg::t_pw_tab              i_pw,
    output logic                              o_q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic [ntt_tfg_pkg::W_COEF-1:0]    o_twiddle
);
    import ntt_tfg_pkg::*;

    // Per-unit stage registers: A = product, B = quotient estimate, C = reduced value
    logic              r_va  [NUM_MM];
    logic [W_PROD-1:0] r_xa  [NUM_MM];
    t_req              r_ra  [NUM_MM];
    logic              r_vb  [NUM_MM];
    logic [W_PROD-1:0] r_xb  [NUM_MM];
    logic [W_COEF-1:0] r_qhb [NUM_MM];
    t_req              r_rb  [NUM_MM];
    logic              r_vc  [NUM_MM];
    logic [W_COEF-1:0] r_acc [NUM_MM];
    t_req              r_rc  [NUM_MM];

    logic              r_ov;
    logic [W_COEF-1:0] r_tw;
    logic [W_COEF-1:0] n_tw;
    logic              en;

    // Whole pipeline advances unless the result register holds an untaken result
    assign en      = ~r_ov | pop;
    assign o_q_pop = en & i_q_valid;

    for (genvar u = 0; u < NUM_MM; u++) begin : g_unit
        logic              v_in;
        logic [W_COEF-1:0] acc_in;
        t_req              req_in;
        logic [W_COEF-1:0] f;

        if (u == 0) begin : g_first
            assign v_in   = i_q_valid;
            assign acc_in = W_COEF'(1);
            assign req_in = i_req;
        end else begin : g_next
            assign v_in   = r_vc[u-1];
            assign acc_in = r_acc[u-1];
            assign req_in = r_rc[u-1];
        end

        // Factor: squared root power for an exponent bit, or 2^16 mod Q in the last unit
        if (u < INDEX_BITS) begin : g_exp
            assign f = req_in.exp[u] ? i_pw[u] : W_COEF'(1);
        end else begin : g_mont
            assign f = req_in.mont ? W_COEF'(MONT_R) : W_COEF'(1);
        end

        // Valid bits
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[u] <= 1'b0;
                r_vb[u] <= 1'b0;
                r_vc[u] <= 1'b0;
            end else if (en) begin
                r_va[u] <= v_in;
                r_vb[u] <= r_va[u];
                r_vc[u] <= r_vb[u];
            end
        end

        // Multiply, estimate quotient, subtract and correct
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_xa[u]  <= W_PROD'(acc_in) * W_PROD'(f);
                r_ra[u]  <= req_in;
                r_xb[u]  <= r_xa[u];
                r_qhb[u] <= barrett_est(r_xa[u]);
                r_rb[u]  <= r_ra[u];
                r_acc[u] <= barrett_fix(r_xb[u], r_qhb[u]);
                r_rc[u]  <= r_rb[u];
            end
        end
    end

    // Center into -HALF_Q..HALF_Q, negate for inverse tables
    always_comb begin
        logic signed [W_COEF:0] s;
        s = signed'({1'b0, r_acc[NUM_MM-1]});
        if (r_acc[NUM_MM-1] > W_COEF'(HALF_Q)) begin
            s = s - (W_COEF+1)'(Q);
        end
        if (r_rc[NUM_MM-1].inv) begin
            s = -s;
        end
        n_tw = s[W_COEF-1:0];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vc[NUM_MM-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tw <= n_tw;
        end
    end

    assign empty     = ~r_ov;
    assign o_twiddle = r_tw;

endmodule
